@@ src/lbl_pkg.sv @@
// ----------------------------------------------------------------------------
// lbl_pkg
// Types, constants and bucket lookup for the LED bar level PWM driver.
// ----------------------------------------------------------------------------
`default_nettype none

package lbl_pkg;

  localparam int unsigned NumLedsDef = 5;   // LEDs on the bar
  localparam int unsigned BarLeds    = 5;   // LEDs that volume buckets can reach
  localparam int unsigned LvlW       = 4;
  localparam int unsigned VolW       = 8;
  localparam int unsigned OutW       = 5;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 4;
  localparam int unsigned BucketW    = 3;

  localparam logic [BucketW-1:0] NoBucket = 3'd7;

  localparam logic [LvlW-1:0] BrightRst = 4'd10;
  localparam logic [LvlW-1:0] DimRst    = 4'd1;
  localparam logic [LvlW-1:0] PeriodRst = 4'd10;

  typedef logic [LvlW-1:0] level_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRIGHT = 2'd0,
    CFG_DIM    = 2'd1,
    CFG_PERIOD = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_UPDATE = 1'b0,
    MODE_TICK   = 1'b1
  } mode_e;

  typedef struct packed {
    logic            mode;
    logic [VolW-1:0] volume;
    logic [VolW-1:0] detect_volume;
  } req_t;

  typedef struct packed {
    level_t bright;
    level_t dim;
    level_t period;
  } cfg_t;

  // 0 -> LED 0, 1..3 -> 1, 4..6 -> 2, 7..9 -> 3, 10..12 -> 4, above -> none
  function automatic logic [BucketW-1:0] bucket_of(input logic [VolW-1:0] v);
    logic [BucketW-1:0] b;
    if (v == 8'd0) begin
      b = 3'd0;
    end else if (v <= 8'd3) begin
      b = 3'd1;
    end else if (v <= 8'd6) begin
      b = 3'd2;
    end else if (v <= 8'd9) begin
      b = 3'd3;
    end else if (v <= 8'd12) begin
      b = 3'd4;
    end else begin
      b = NoBucket;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ src/lbl_if.sv @@
// ----------------------------------------------------------------------------
// lbl_req_if / lbl_rsp_if
// Valid/ready channels for requests and LED on-bit results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbl_req_if
  import lbl_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            mode;
  logic [VolW-1:0] volume;
  logic [VolW-1:0] detect_volume;

  modport source (output valid, output mode, output volume, output detect_volume,
                  input ready);
  modport sink   (input valid, input mode, input volume, input detect_volume,
                  output ready);
endinterface

interface lbl_rsp_if
  import lbl_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [OutW-1:0] led_on;

  modport source (output valid, output led_on, input ready);
  modport sink   (input valid, input led_on, output ready);
endinterface

`default_nettype wire

@@ src/lbl_level_calc.sv @@
// ----------------------------------------------------------------------------
// lbl_level_calc
// Next LED levels, next PWM step and on bits for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module lbl_level_calc
  import lbl_pkg::*;
#(
  parameter int unsigned NUM_LEDS = NumLedsDef
) (
  input  req_t                          req_i,
  input  cfg_t                          cfg_i,
  input  logic [NUM_LEDS-1:0][LvlW-1:0] levels_i,
  input  level_t                        step_i,
  output logic [NUM_LEDS-1:0][LvlW-1:0] levels_o,
  output level_t                        step_o,
  output logic [OutW-1:0]               led_on_o
);

  logic [BucketW-1:0]            main_b;
  logic [BucketW-1:0]            det_b;
  logic [NUM_LEDS-1:0][LvlW-1:0] upd_lvl;
  level_t                        step_inc;

  assign main_b = bucket_of(req_i.volume);
  assign det_b  = bucket_of(req_i.detect_volume);

  // main bucket gets bright, detected bucket gets dim if still dark
  always_comb begin
    for (int k = 0; k < int'(NUM_LEDS); k++) begin
      if (k < int'(BarLeds) && main_b == BucketW'(k)) begin
        upd_lvl[k] = cfg_i.bright;
      end else begin
        upd_lvl[k] = '0;
      end
      if (k < int'(BarLeds) && det_b == BucketW'(k) && upd_lvl[k] == '0) begin
        upd_lvl[k] = cfg_i.dim;
      end
    end
  end

  assign levels_o = (req_i.mode == MODE_TICK) ? levels_i : upd_lvl;

  // advance on tick, wrap at the period
  assign step_inc = step_i + 4'd1;
  always_comb begin
    if (req_i.mode == MODE_TICK) begin
      step_o = (step_inc >= cfg_i.period) ? '0 : step_inc;
    end else begin
      step_o = step_i;
    end
  end

  for (genvar g = 0; g < int'(OutW); g++) begin : g_on
    if (g < int'(NUM_LEDS)) begin : g_led
      assign led_on_o[g] = (levels_o[g] > step_i);
    end else begin : g_none
      assign led_on_o[g] = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ src/led_bar_level_pwm_driver_unit.sv @@
// ----------------------------------------------------------------------------
// led_bar_level_pwm_driver_unit
// Five-LED volume bar with PWM dimming: level updates and PWM ticks.
// ----------------------------------------------------------------------------
// Pipeline: a request is accepted into the input register and its result
// is valid once it reaches the result register. Throughput: one request
// per cycle; the level logic sits between those two registers and stalls
// only on result backpressure.
// Reset: LED levels and PWM step clear to zero, bright/dim/period return to
// 10/1/10, both pipeline stages empty.
`default_nettype none

module led_bar_level_pwm_driver_unit
  import lbl_pkg::*;
#(
  parameter int unsigned NUM_LEDS = NumLedsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  lbl_req_if.sink                  req_i,
  lbl_rsp_if.source                rsp_o
);

  cfg_t                          cfg_q;
  req_t                          req_q;
  logic                          req_vld_q;
  logic [NUM_LEDS-1:0][LvlW-1:0] lvl_q, lvl_d;
  level_t                        step_q, step_d;
  logic [OutW-1:0]               led_q, led_d;
  logic                          out_vld_q;
  logic                          advance;

  assign advance     = req_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright <= BrightRst;
      cfg_q.dim    <= DimRst;
      cfg_q.period <= PeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BRIGHT: cfg_q.bright <= cfg_data_i;
        CFG_DIM:    cfg_q.dim    <= cfg_data_i;
        CFG_PERIOD: cfg_q.period <= cfg_data_i;
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.mode          <= req_i.mode;
      req_q.volume        <= req_i.volume;
      req_q.detect_volume <= req_i.detect_volume;
    end
  end

  lbl_level_calc #(
    .NUM_LEDS (NUM_LEDS)
  ) u_calc (
    .req_i    (req_q),
    .cfg_i    (cfg_q),
    .levels_i (lvl_q),
    .step_i   (step_q),
    .levels_o (lvl_d),
    .step_o   (step_d),
    .led_on_o (led_d)
  );

  // state and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q     <= '0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        lvl_q     <= lvl_d;
        step_q    <= step_d;
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      led_q <= led_d;
    end
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.led_on = led_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED bar level PWM driver: level updates and
// PWM ticks are sent over the request channel, each LED on-bit result is
// checked against a cycle-free model of the bar, with random idling on both
// channels and register settings changed between traffic phases.
// ----------------------------------------------------------------------------

module tb;
  import lbl_pkg::*;

  localparam int unsigned NLeds = NumLedsDef;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  lbl_req_if req_if ();
  lbl_rsp_if rsp_if ();

  led_bar_level_pwm_driver_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Model of the bar
  level_t cfg_bright = BrightRst;
  level_t cfg_dim    = DimRst;
  level_t cfg_period = PeriodRst;
  level_t led_lvl [NLeds];
  level_t pwm_pos    = '0;

  logic [OutW-1:0] led_on_q [$];
  logic [OutW-1:0] exp_led_on;

  int unsigned sent_cnt = 0;
  int unsigned rcv_cnt  = 0;
  int unsigned fail_cnt = 0;
  int unsigned pend_gap = 0;
  int unsigned hold_cnt = 0;
  bit          req_up   = 1'b0;
  bit          gap_on   = 1'b0;
  bit          stall_on = 1'b0;
  logic        rdy_next;

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("[led_bar_level_pwm_driver_unit] ERROR");
    $finish;
  end

  // Bucket index of a volume; 99 means the volume lights no LED
  function automatic int vol_bucket(input logic [VolW-1:0] v);
    int b;
    if (v == 8'd0) begin
      b = 0;
    end else if (v <= 8'd3) begin
      b = 1;
    end else if (v <= 8'd6) begin
      b = 2;
    end else if (v <= 8'd9) begin
      b = 3;
    end else if (v <= 8'd12) begin
      b = 4;
    end else begin
      b = 99;
    end
    return b;
  endfunction

  function automatic logic [OutW-1:0] lit_mask();
    logic [OutW-1:0] m;
    m = '0;
    for (int k = 0; k < NLeds && k < OutW; k++) begin
      if (led_lvl[k] > pwm_pos) m[k] = 1'b1;
    end
    return m;
  endfunction

  task automatic predict_led_on(input logic mode, input logic [VolW-1:0] vol,
                                input logic [VolW-1:0] det);
    int mb;
    int db;
    if (mode == MODE_UPDATE) begin
      mb = vol_bucket(vol);
      db = vol_bucket(det);
      for (int k = 0; k < NLeds; k++) begin
        led_lvl[k] = (k == mb) ? cfg_bright : '0;
      end
      if (db < NLeds && led_lvl[db] == '0) led_lvl[db] = cfg_dim;
      led_on_q.push_back(lit_mask());
    end else begin
      // result compares with the step before it advances
      led_on_q.push_back(lit_mask());
      pwm_pos = pwm_pos + 1'b1;
      if (pwm_pos >= cfg_period) pwm_pos = '0;
    end
  endtask

  initial begin
    for (int k = 0; k < NLeds; k++) led_lvl[k] = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BRIGHT: cfg_bright = cfg_data;
          CFG_DIM:    cfg_dim    = cfg_data;
          CFG_PERIOD: cfg_period = cfg_data;
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        predict_led_on(req_if.mode, req_if.volume, req_if.detect_volume);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (led_on_q.size() == 0) begin
        $error("led_on result with no request pending: actual %b", rsp_if.led_on);
        fail_cnt++;
      end else begin
        exp_led_on = led_on_q.pop_front();
        if (rsp_if.led_on !== exp_led_on) begin
          $error("led_on mismatch: expected %b actual %b", exp_led_on, rsp_if.led_on);
          fail_cnt++;
        end
      end
      rcv_cnt++;
    end
  end

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(9, 29);
  endfunction

  // Result backpressure: hold each ready level for a random stretch
  always @(posedge clk_i) begin
    if (!stall_on) begin
      rsp_if.ready <= 1'b1;
      hold_cnt = 0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end else begin
      rdy_next = ($urandom_range(0, 99) < 65);
      rsp_if.ready <= rdy_next;
      hold_cnt = rdy_next ? $urandom_range(0, 6) : stall_len();
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (!gap_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 9);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_req(input mode_e m, input logic [VolW-1:0] v,
                          input logic [VolW-1:0] d);
    if (pend_gap != 0) repeat (pend_gap) @(posedge clk_i);
    req_if.valid         <= 1'b1;
    req_if.mode          <= m;
    req_if.volume        <= v;
    req_if.detect_volume <= d;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_cnt++;
    // keep valid up only when the next request follows right away
    pend_gap = draw_gap();
    if (pend_gap != 0) req_if.valid <= 1'b0;
    req_up = (pend_gap == 0);
  endtask

  task automatic drain_results();
    if (req_up) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
    end
    while (rcv_cnt < sent_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_cfg(input level_t b, input level_t d, input level_t p);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BRIGHT;
    cfg_data <= b;
    @(posedge clk_i);
    cfg_idx  <= CFG_DIM;
    cfg_data <= d;
    @(posedge clk_i);
    cfg_idx  <= CFG_PERIOD;
    cfg_data <= p;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // All levels clear after reset, so a tick lights nothing
  task automatic test_reset_state();
    send_req(MODE_TICK, 8'd0, 8'd0);
  endtask

  task automatic test_bucket_edges();
    send_req(MODE_UPDATE, 8'd0, 8'd13);
    send_req(MODE_UPDATE, 8'd1, 8'd0);
    send_req(MODE_UPDATE, 8'd3, 8'd4);
    send_req(MODE_UPDATE, 8'd6, 8'd7);
    send_req(MODE_UPDATE, 8'd9, 8'd10);
    send_req(MODE_UPDATE, 8'd12, 8'd255);
    send_req(MODE_UPDATE, 8'd13, 8'd0);
    send_req(MODE_UPDATE, 8'd255, 8'd170);
    send_req(MODE_UPDATE, 8'd5, 8'd5);
  endtask

  // Shared bucket with bright at zero falls back to dim; period one holds step
  task automatic test_shared_bucket();
    load_cfg(4'd0, 4'd15, 4'd1);
    send_req(MODE_UPDATE, 8'd2, 8'd2);
    send_req(MODE_TICK, 8'd255, 8'd255);
    send_req(MODE_TICK, 8'd0, 8'd0);
  endtask

  task automatic test_pwm_wrap();
    load_cfg(4'd15, 4'd0, 4'd3);
    send_req(MODE_UPDATE, 8'd11, 8'd8);
    repeat (4) send_req(MODE_TICK, 8'd0, 8'd0);
  endtask

  // Drop the period below the current step: the next tick must wrap
  task automatic test_period_shrink();
    load_cfg(4'd15, 4'd1, 4'd8);
    send_req(MODE_UPDATE, 8'd7, 8'd1);
    repeat (6) send_req(MODE_TICK, 8'd0, 8'd0);
    load_cfg(4'd15, 4'd1, 4'd2);
    send_req(MODE_UPDATE, 8'd10, 8'd4);
    send_req(MODE_TICK, 8'd0, 8'd0);
    send_req(MODE_TICK, 8'd0, 8'd0);
  endtask

  function automatic level_t pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return 4'd0;
    if (r < 40) return 4'd15;
    return level_t'($urandom_range(0, 15));
  endfunction

  function automatic level_t pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 4'd1;
    if (r < 50) return 4'd15;
    return level_t'($urandom_range(1, 15));
  endfunction

  // Mostly volumes around the buckets, the rest anywhere in range
  function automatic logic [VolW-1:0] pick_vol();
    if ($urandom_range(0, 99) < 80) return VolW'($urandom_range(0, 14));
    return VolW'($urandom_range(0, 255));
  endfunction

  task automatic test_random_traffic();
    mode_e m;
    for (int ph = 0; ph < 10; ph++) begin
      gap_on   = (ph % 4 != 0);
      stall_on = (ph % 3 != 0);
      if (ph == 0) begin
        load_cfg(4'd15, 4'd15, 4'd15);
      end else if (ph == 1) begin
        load_cfg(4'd0, 4'd0, 4'd1);
      end else begin
        load_cfg(pick_level(), pick_level(), pick_period());
      end
      for (int i = 0; i < 200; i++) begin
        m = ($urandom_range(0, 99) < 45) ? MODE_TICK : MODE_UPDATE;
        send_req(m, pick_vol(), pick_vol());
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_BRIGHT;
    cfg_data             = '0;
    req_if.valid         = 1'b0;
    req_if.mode          = MODE_UPDATE;
    req_if.volume        = '0;
    req_if.detect_volume = '0;
    rsp_if.ready         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_bucket_edges();
    test_shared_bucket();
    test_pwm_wrap();
    test_period_shrink();
    test_random_traffic();

    drain_results();
    if (led_on_q.size() != 0) begin
      $error("led_on results missing: %0d still expected", led_on_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("[led_bar_level_pwm_driver_unit] OK");
    end else begin
      $display("[led_bar_level_pwm_driver_unit] ERROR");
    end
    $finish;
  end

endmodule
